// ===== rtl/gqtl_pkg.sv =====
// Shared types, codes and saturation helpers for the glyph quad text layout block.
package gqtl_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;

  localparam int SPACE_ADVANCE = 3;
  localparam int GLYPH_GAP     = 1;
  localparam int WRAP_MARGIN   = 2;

  localparam logic [2:0] VTX_LAST = 3'd5;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  width;
  } glyph_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         char_code;
    logic               first_char;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } draw_item_t;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] right_x;
    logic signed [15:0] top_y;
    logic signed [15:0] bot_y;
    logic [15:0]        u_left;
    logic [15:0]        u_right;
  } quad_t;

  function automatic logic signed [18:0] sext19(input logic signed [15:0] v);
    return $signed({{3{v[15]}}, v});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [15:0] offset_add(input logic [15:0] lo, input logic [8:0] d);
    logic [16:0] s;
    s = {1'b0, lo} + {8'b0, d};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

endpackage

// ===== rtl/gqtl_if.sv =====
// Valid/ready channel interfaces for draw/load requests and output vertices.
interface gqtl_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [6:0]         glyph_index;
  logic [15:0]        tex_left;
  logic [15:0]        tex_right;
  logic [7:0]         glyph_width;
  logic [7:0]         char_code;
  logic               first_char;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, func, glyph_index, tex_left, tex_right, glyph_width,
                  char_code, first_char, start_x, start_y, input ready);
  modport sink (input valid, func, glyph_index, tex_left, tex_right, glyph_width,
                char_code, first_char, start_x, start_y, output ready);
endinterface

interface gqtl_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        tex_u;
  logic               tex_v;
  logic               last_vertex;

  modport source (output valid, pos_x, pos_y, tex_u, tex_v, last_vertex, input ready);
  modport sink (input valid, pos_x, pos_y, tex_u, tex_v, last_vertex, output ready);
endinterface

// ===== rtl/gqtl_layout.sv =====
// Pen state, line wrap test and quad corner computation for one draw item.
module gqtl_layout #(
  parameter int GLYPH_COUNT  = 95,
  parameter int GLYPH_HEIGHT = 16,
  parameter int LINE_STEP    = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  gqtl_pkg::draw_item_t item,
  input  gqtl_pkg::glyph_t    glyph,
  input  logic [14:0]         max_line_width,
  input  logic                quad_free,
  output logic                item_advance,
  output logic                quad_load,
  output gqtl_pkg::quad_t     quad
);
  import gqtl_pkg::*;

  logic signed [15:0] pen_x, pen_y;
  logic [15:0]        line_offset;
  logic               string_started;

  logic signed [15:0] pen_x_next, pen_y_next;
  logic [15:0]        line_offset_next;

  logic [7:0]         idx;
  logic               printable;
  logic               is_draw;
  logic               needs_quad;
  logic [17:0]        wrap_sum;
  logic               wrap;
  logic signed [15:0] px0, py0;
  logic [15:0]        lo0;

  always_comb begin
    is_draw   = item.func == FUNC_DRAW;
    idx       = item.char_code - CODE_FIRST;
    printable = (item.char_code >= CODE_FIRST) && (item.char_code <= CODE_LAST) &&
                ({1'b0, idx} < 9'(GLYPH_COUNT));
    wrap_sum  = {2'b0, line_offset} + {10'b0, glyph.width} + 18'(WRAP_MARGIN);
    wrap      = (max_line_width != 15'd0) && (wrap_sum > {3'b0, max_line_width});

    px0 = pen_x;
    py0 = pen_y;
    lo0 = line_offset;
    if (item.first_char) begin
      px0 = item.start_x;
      py0 = item.start_y;
      lo0 = 16'd0;
    end else if (string_started && printable && wrap) begin
      px0 = sat16(sext19(pen_x) - $signed({3'b0, line_offset}));
      py0 = sat16(sext19(pen_y) - $signed(19'(LINE_STEP)));
      lo0 = 16'd0;
    end

    pen_x_next       = px0;
    pen_y_next       = py0;
    line_offset_next = lo0;
    needs_quad       = 1'b0;
    if (printable) begin
      if (item.char_code == CODE_SPACE) begin
        pen_x_next       = sat16(sext19(px0) + $signed(19'(SPACE_ADVANCE)));
        line_offset_next = offset_add(lo0, 9'(SPACE_ADVANCE));
      end else begin
        needs_quad       = 1'b1;
        pen_x_next       = sat16(sext19(px0) + $signed({11'b0, glyph.width}) +
                                 $signed(19'(GLYPH_GAP)));
        line_offset_next = offset_add(lo0, {1'b0, glyph.width} + 9'(GLYPH_GAP));
      end
    end

    quad.left_x  = px0;
    quad.right_x = sat16(sext19(px0) + $signed({11'b0, glyph.width}));
    quad.top_y   = py0;
    quad.bot_y   = sat16(sext19(py0) - $signed(19'(GLYPH_HEIGHT)));
    quad.u_left  = glyph.left;
    quad.u_right = glyph.right;

    item_advance = !item_valid || !is_draw || !needs_quad || quad_free;
    quad_load    = item_valid && is_draw && needs_quad && quad_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x          <= '0;
      pen_y          <= '0;
      line_offset    <= '0;
      string_started <= 1'b0;
    end else if (item_valid && is_draw && item_advance) begin
      pen_x       <= pen_x_next;
      pen_y       <= pen_y_next;
      line_offset <= line_offset_next;
      if (item.first_char) begin
        string_started <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gqtl_emit.sv =====
// Quad holding register and six-vertex sequencer driving the vertex channel.
module gqtl_emit (
  input  logic              clk,
  input  logic              rst,
  input  gqtl_pkg::quad_t   quad_in,
  input  logic              quad_load,
  output logic              quad_free,
  gqtl_vtx_if.source        vtx
);
  import gqtl_pkg::*;

  quad_t      quad;
  logic       busy;
  logic [2:0] vcount;
  logic       xfer;

  assign xfer      = vtx.valid && vtx.ready;
  assign quad_free = !busy || (xfer && vcount == VTX_LAST);
  assign vtx.valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      vcount <= '0;
    end else if (quad_load) begin
      busy   <= 1'b1;
      vcount <= '0;
    end else if (xfer) begin
      if (vcount == VTX_LAST) begin
        busy <= 1'b0;
      end else begin
        vcount <= vcount + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (quad_load) begin
      quad <= quad_in;
    end
  end

  // order: TL, BR, BL, TL, TR, BR
  always_comb begin
    vtx.last_vertex = 1'b0;
    case (vcount)
      3'd0, 3'd3: begin
        vtx.pos_x = quad.left_x;
        vtx.pos_y = quad.top_y;
        vtx.tex_u = quad.u_left;
        vtx.tex_v = 1'b0;
      end
      3'd1: begin
        vtx.pos_x = quad.right_x;
        vtx.pos_y = quad.bot_y;
        vtx.tex_u = quad.u_right;
        vtx.tex_v = 1'b1;
      end
      3'd2: begin
        vtx.pos_x = quad.left_x;
        vtx.pos_y = quad.bot_y;
        vtx.tex_u = quad.u_left;
        vtx.tex_v = 1'b1;
      end
      3'd4: begin
        vtx.pos_x = quad.right_x;
        vtx.pos_y = quad.top_y;
        vtx.tex_u = quad.u_right;
        vtx.tex_v = 1'b0;
      end
      default: begin
        vtx.pos_x       = quad.right_x;
        vtx.pos_y       = quad.bot_y;
        vtx.tex_u       = quad.u_right;
        vtx.tex_v       = 1'b1;
        vtx.last_vertex = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/glyph_quad_text_layout_core.sv =====
// Top level: request register, glyph table, layout stage and vertex emitter.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    func, glyph_index, tex_*, glyph_width, char_code, first_char, start_*
//  vtx      out  valid/ready    pos_x, pos_y, tex_u, tex_v, last_vertex
//  cfg      in   cfg_we         cfg_data = max_line_width
//
//  A drawn glyph passes the request and quad registers, then leaves as six vertex transfers.
//  Loads, spaces and dropped codes emit no vertices and never wait on the emitter.
//  Reset clears pen, line offset and wrap width; the glyph table is not cleared.
//  A vertex stall holds the emitter; a glyph waiting for it then holds the layout stage and req.ready.
module glyph_quad_text_layout_core #(
  parameter int GLYPH_COUNT  = 95,
  parameter int GLYPH_HEIGHT = 16,
  parameter int LINE_STEP    = 13
) (
  input  logic        clk,
  input  logic        rst,
  gqtl_req_if.sink    req,
  gqtl_vtx_if.source  vtx,
  input  logic        cfg_we,
  input  logic [14:0] cfg_data
);
  import gqtl_pkg::*;

  localparam int ADDR_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  glyph_t      glyph_table [GLYPH_COUNT];
  glyph_t      rd_glyph;
  draw_item_t  s1;
  logic        s1_valid;
  logic [14:0] max_line_width;

  logic        accept;
  logic        s1_advance;
  quad_t       quad;
  logic        quad_load;
  logic        quad_free;
  logic [8:0]  waddr;
  logic [8:0]  raddr;

  assign req.ready = s1_advance;
  assign accept    = req.valid && req.ready;
  assign waddr     = {2'b0, req.glyph_index};
  assign raddr     = {1'b0, req.char_code - CODE_FIRST};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_width <= '0;
    end else if (cfg_we) begin
      max_line_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.func       <= req.func;
      s1.char_code  <= req.char_code;
      s1.first_char <= req.first_char;
      s1.start_x    <= req.start_x;
      s1.start_y    <= req.start_y;
      rd_glyph      <= glyph_table[raddr[ADDR_W-1:0]];
    end
    if (accept && req.func == FUNC_LOAD && waddr < 9'(GLYPH_COUNT)) begin
      glyph_table[waddr[ADDR_W-1:0]] <= '{left: req.tex_left, right: req.tex_right,
                                          width: req.glyph_width};
    end
  end

  gqtl_layout #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .LINE_STEP   (LINE_STEP)
  ) u_layout (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (s1_valid),
    .item          (s1),
    .glyph         (rd_glyph),
    .max_line_width(max_line_width),
    .quad_free     (quad_free),
    .item_advance  (s1_advance),
    .quad_load     (quad_load),
    .quad          (quad)
  );

  gqtl_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .quad_in  (quad),
    .quad_load(quad_load),
    .quad_free(quad_free),
    .vtx      (vtx)
  );

  a_load_needs_free: assert property (@(posedge clk) disable iff (rst)
    quad_load |-> quad_free)
    else $error("quad loaded while emitter busy");

  a_load_item_no_quad: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.func == FUNC_LOAD) |-> !quad_load)
    else $error("load item produced a quad");

  a_stall_holds_glyph: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> $stable(rd_glyph) && $stable(s1))
    else $error("stalled layout item changed");

endmodule
